@@ sv/htl_pkg.sv @@
// ----------------------------------------------------------------------------
// htl_pkg
// Shared types and codes for the host table: result status codes, opcodes,
// FSM states, the stored entry record and the beat payloads.
// ----------------------------------------------------------------------------
package htl_pkg;

  // Item opcodes
  typedef enum logic {
    OP_ANNOUNCE = 1'b0,
    OP_LOOKUP   = 1'b1
  } htl_op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ADDED        = 3'd1,
    ST_CONFLICT     = 3'd2,
    ST_OWN_CONFLICT = 3'd3,
    ST_FULL         = 3'd4,
    ST_NOT_FOUND    = 3'd5
  } htl_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } htl_state_t;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int NAMEL_W = 64;
  localparam int NAMEH_W = 16;
  localparam int STAMP_W = 32;
  localparam int IDX_W   = 6;
  localparam int HCNT_W  = 7;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
    logic [NAMEL_W-1:0] name_low;
    logic [NAMEH_W-1:0] name_high;
    logic [STAMP_W-1:0] stamp;
  } htl_entry_t;

  // Latched input beat
  typedef struct packed {
    htl_op_t            op;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
    logic [NAMEL_W-1:0] name_low;
    logic [NAMEH_W-1:0] name_high;
    logic [STAMP_W-1:0] stamp;
  } htl_item_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    htl_status_t       status;
    logic [IDX_W-1:0]  entry_index;
    logic [HCNT_W-1:0] host_count;
  } htl_result_t;

endpackage

@@ sv/htl_if.sv @@
// ----------------------------------------------------------------------------
// htl_in_if / htl_out_if
// Valid/ready channels of the host table: announce or lookup beats in,
// result beats out.
// ----------------------------------------------------------------------------
interface htl_in_if
  import htl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                op;
  logic [MAC_W-1:0]    mac_address;
  logic [IP_W-1:0]     ip_address;
  logic [NAMEL_W-1:0]  name_low;
  logic [NAMEH_W-1:0]  name_high;
  logic [STAMP_W-1:0]  now_seconds;

  modport source (
    output valid, op, mac_address, ip_address, name_low, name_high, now_seconds,
    input  ready
  );
  modport sink (
    input  valid, op, mac_address, ip_address, name_low, name_high, now_seconds,
    output ready
  );
endinterface

interface htl_out_if
  import htl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [IDX_W-1:0]  entry_index;
  logic [HCNT_W-1:0] host_count;

  modport source (
    output valid, status, entry_index, host_count,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, host_count,
    output ready
  );
endinterface

@@ sv/htl_ram.sv @@
// ----------------------------------------------------------------------------
// htl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module htl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/htl_ctrl.sv @@
// ----------------------------------------------------------------------------
// htl_ctrl
// Sequencer of the host table: latches one beat, scans the held entries
// through the RAM read port with a single MAC/IP compare unit, then decides
// the result and, for an announce that refreshes or adds a host, writes the entry.
// ----------------------------------------------------------------------------
module htl_ctrl
  import htl_pkg::*;
#(
  parameter int MAX_HOSTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  htl_in_if.sink               in_bus,
  input  logic [MAC_W-1:0]     own_mac,
  input  logic                 res_free,
  output logic                 res_valid,
  output htl_result_t          res,
  output logic                 wr_en,
  output logic [(MAX_HOSTS > 1 ? $clog2(MAX_HOSTS) : 1)-1:0] wr_addr,
  output htl_entry_t           wr_data,
  output logic                 rd_en,
  output logic [(MAX_HOSTS > 1 ? $clog2(MAX_HOSTS) : 1)-1:0] rd_addr,
  input  htl_entry_t           rd_data
);

  localparam int AW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int CW = $clog2(MAX_HOSTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HOSTS);

  htl_state_t      state_r, state_nxt;
  htl_item_t       item_r, item_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic            hit_r, hit_nxt;
  logic [AW-1:0]   hit_idx_r, hit_idx_nxt;
  logic            clash_r, clash_nxt;
  logic            issue;
  logic            mac_eq;
  logic            ip_eq;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    clash_r   <= clash_nxt;
  end

  // shared compare unit on the entry read last cycle
  assign mac_eq = cmp_v_r && (rd_data.mac == item_r.mac);
  assign ip_eq  = cmp_v_r && (rd_data.ip == item_r.ip);
  assign issue  = (state_r == S_SCAN) && (idx_r < count_r) && !mac_eq;

  assign in_bus.ready = (state_r == S_IDLE);
  assign rd_en        = issue;
  assign rd_addr      = idx_r[AW-1:0];

  // entry written back: always the latched beat
  assign wr_data.mac       = item_r.mac;
  assign wr_data.ip        = item_r.ip;
  assign wr_data.name_low  = item_r.name_low;
  assign wr_data.name_high = item_r.name_high;
  assign wr_data.stamp     = item_r.stamp;

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_v_nxt   = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    clash_nxt   = clash_r;
    wr_en       = 1'b0;
    wr_addr     = hit_idx_r;
    res_valid   = 1'b0;
    res.status      = ST_OK;
    res.entry_index = '0;
    res.host_count  = HCNT_W'(count_r);

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          item_nxt.op        = htl_op_t'(in_bus.op);
          item_nxt.mac       = in_bus.mac_address;
          item_nxt.ip        = in_bus.ip_address;
          item_nxt.name_low  = in_bus.name_low;
          item_nxt.name_high = in_bus.name_high;
          item_nxt.stamp     = in_bus.now_seconds;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          clash_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // one read issued and one compare done per cycle
        if (issue) begin
          idx_nxt     = idx_r + 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
        end
        if (ip_eq) begin
          clash_nxt = 1'b1;
        end
        if (mac_eq) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
        end
        if (mac_eq || !issue) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (item_r.op == OP_LOOKUP) begin
            if (hit_r) begin
              res.status      = ST_OK;
              res.entry_index = IDX_W'(hit_idx_r);
            end else begin
              res.status = ST_NOT_FOUND;
            end
          end else if (hit_r) begin
            // known host: refresh in place
            wr_en           = 1'b1;
            wr_addr         = hit_idx_r;
            res.status      = ST_OK;
            res.entry_index = IDX_W'(hit_idx_r);
          end else if (count_r >= MAX_CNT) begin
            res.status = ST_FULL;
          end else if (clash_r) begin
            res.status = (item_r.mac == own_mac) ? ST_OWN_CONFLICT : ST_CONFLICT;
          end else begin
            // new host appended at the fill count
            wr_en           = 1'b1;
            wr_addr         = count_r[AW-1:0];
            count_nxt       = count_r + 1'b1;
            res.status      = ST_ADDED;
            res.entry_index = IDX_W'(count_r);
          end
          res.host_count = HCNT_W'(count_nxt);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("host count above table size");

  // count only grows, by one, together with a table write
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != count_nxt |-> wr_en && count_nxt == count_r + 1'b1)
    else $error("host count changed without an append");

  // reads stay below the fill count
  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> {1'b0, rd_addr} < {1'b0, count_r})
    else $error("read of an entry not yet filled");

  // a new item is only taken after the previous result was issued
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> state_r == S_IDLE && !cmp_v_r)
    else $error("sequencer not idle after result");

  // table writes never happen while the scan is reading
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && res_valid)
    else $error("write outside the decide step");
`endif

endmodule

@@ sv/host_table_learn_and_lookup.sv @@
// ----------------------------------------------------------------------------
// host_table_learn_and_lookup
// Host table keyed by 48-bit MAC: learns, refreshes and looks up hosts.
// ----------------------------------------------------------------------------
// One beat at a time. An item is accepted only when the sequencer is idle,
// then the held entries are scanned through the single RAM read port, one
// entry per cycle, with the MAC/IP compare pipelined behind the registered
// read. The scan covers all held entries, or those up to and including the
// matching MAC. The result sits in an output register; the block is ready
// for the next item once the result is loaded there, whether or not it has
// been taken. No clearing pass is needed after reset: only entries below the
// host count are ever read.
// ----------------------------------------------------------------------------
module host_table_learn_and_lookup
  import htl_pkg::*;
#(
  parameter int MAX_HOSTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  htl_in_if.sink           in_bus,
  htl_out_if.source        out_bus,
  input  logic             cfg_we,
  input  logic [MAC_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

  logic [MAC_W-1:0] own_mac_r, own_mac_nxt;
  logic             out_valid_r, out_valid_nxt;
  htl_result_t      out_res_r, out_res_nxt;
  logic             res_free;
  logic             res_valid;
  htl_result_t      res;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  htl_entry_t       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  htl_entry_t       rd_data;

  // own MAC register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      own_mac_r   <= own_mac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    own_mac_nxt   = cfg_we ? cfg_wdata : own_mac_r;
    res_free      = !out_valid_r || out_bus.ready;
    out_valid_nxt = res_valid ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);
    out_res_nxt   = res_valid ? res : out_res_r;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_res_r.status;
  assign out_bus.entry_index = out_res_r.entry_index;
  assign out_bus.host_count  = out_res_r.host_count;

  // sequencer with the shared compare unit
  htl_ctrl #(
    .MAX_HOSTS (MAX_HOSTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .own_mac   (own_mac_r),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // entry storage
  htl_ram #(
    .WIDTH ($bits(htl_entry_t)),
    .DEPTH (MAX_HOSTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ tb/host_table_learn_and_lookup_tb.sv @@
// ----------------------------------------------------------------------------
// host_table_learn_and_lookup_tb
// Self-checking bench for the MAC-keyed host table. Directed beats cover
// adding hosts, refreshing known hosts, plain and own IP conflicts, and
// lookups. Random traffic then fills the table to its limit and keeps going
// into the full-table region. A shadow copy of the table predicts every
// result, and each result beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module host_table_learn_and_lookup_tb;
  import htl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  // Idle slack after the last awaited result, to give the block time to settle
  localparam int SETTLE_CYCLES = 80;

  localparam logic [MAC_W-1:0] HOST_A = 48'h0A1B_2C3D_4E5F;
  localparam logic [MAC_W-1:0] HOST_B = 48'h1234_5678_9ABC;
  localparam logic [IP_W-1:0]  LAN_IP = 32'hC0A8_0001;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [MAC_W-1:0] cfg_wdata;

  htl_in_if  in_ch ();
  htl_out_if out_ch ();

  host_table_learn_and_lookup #(
    .MAX_HOSTS(TABLE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the host table: only MAC, IP and the count are observable
  logic [MAC_W-1:0] shadow_mac [TABLE_DEPTH];
  logic [IP_W-1:0]  shadow_ip  [TABLE_DEPTH];
  int               shadow_count = 0;
  logic [MAC_W-1:0] shadow_own_mac = '0;

  htl_result_t awaited_results [$];
  int          mismatch_count = 0;
  int          src_idle_pct   = 0;
  int          sink_idle_pct  = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted beat to the shadow table and return what the block owes
  function automatic htl_result_t learn_host(htl_item_t beat);
    htl_result_t r;
    int          hit   = -1;
    bit          clash = 1'b0;
    r.status      = ST_OK;
    r.entry_index = '0;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_mac[i] == beat.mac) hit = i;
    if (beat.op == OP_LOOKUP) begin
      if (hit >= 0) begin
        r.entry_index = IDX_W'(hit);
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (hit >= 0) begin
      // known MAC: refreshed whatever its IP, no conflict check
      shadow_ip[hit] = beat.ip;
      r.entry_index  = IDX_W'(hit);
    end else if (shadow_count >= TABLE_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      for (int i = 0; i < shadow_count; i++)
        if (shadow_ip[i] == beat.ip) clash = 1'b1;
      if (clash) begin
        r.status = (beat.mac == shadow_own_mac) ? ST_OWN_CONFLICT : ST_CONFLICT;
      end else begin
        shadow_mac[shadow_count] = beat.mac;
        shadow_ip[shadow_count]  = beat.ip;
        r.entry_index = IDX_W'(shadow_count);
        shadow_count++;
        r.status = ST_ADDED;
      end
    end
    r.host_count = HCNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Result check first, then prediction of any beat accepted on this edge
  always @(posedge clk) begin : watch_beats
    htl_result_t want;
    htl_item_t   seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with no result awaited");
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status || out_ch.entry_index !== want.entry_index ||
              out_ch.host_count !== want.host_count)
            report_mismatch($sformatf(
              "status/index/count got %0d/%0d/%0d want %0d/%0d/%0d",
              out_ch.status, out_ch.entry_index, out_ch.host_count,
              want.status, want.entry_index, want.host_count));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.op        = htl_op_t'(in_ch.op);
        seen.mac       = in_ch.mac_address;
        seen.ip        = in_ch.ip_address;
        seen.name_low  = in_ch.name_low;
        seen.name_high = in_ch.name_high;
        seen.stamp     = in_ch.now_seconds;
        awaited_results.push_back(learn_host(seen));
      end
    end
  end

  // Result sink back-pressure
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

  // Drive one beat and hold it until accepted
  task automatic send_beat(htl_item_t beat);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= beat.op;
    in_ch.mac_address <= beat.mac;
    in_ch.ip_address  <= beat.ip;
    in_ch.name_low    <= beat.name_low;
    in_ch.name_high   <= beat.name_high;
    in_ch.now_seconds <= beat.stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every awaited result is back
  task automatic settle_table();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_own_mac(logic [MAC_W-1:0] mac);
    settle_table();
    cfg_we    <= 1'b1;
    cfg_wdata <= mac;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_own_mac = mac;
  endtask

  task automatic announce(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                          logic [NAMEL_W-1:0] nlo, logic [NAMEH_W-1:0] nhi,
                          logic [STAMP_W-1:0] stamp);
    htl_item_t beat;
    beat = '{op: OP_ANNOUNCE, mac: mac, ip: ip, name_low: nlo, name_high: nhi,
             stamp: stamp};
    send_beat(beat);
  endtask

  // Lookup with junk in the fields the block should ignore
  task automatic look_up(logic [MAC_W-1:0] mac);
    htl_item_t beat;
    beat = '{op: OP_LOOKUP, mac: mac, ip: $urandom, name_low: {$urandom, $urandom},
             name_high: 16'($urandom), stamp: $urandom};
    send_beat(beat);
  endtask

  // Random beat, steered toward lookups, adds, refreshes and IP clashes
  function automatic htl_item_t make_host_item(int add_pct);
    htl_item_t   beat;
    logic [63:0] wide;
    int          roll;
    wide           = {$urandom, $urandom};
    beat.op        = OP_ANNOUNCE;
    beat.mac       = wide[MAC_W-1:0];
    beat.ip        = $urandom;
    beat.name_low  = {$urandom, $urandom};
    beat.name_high = 16'($urandom);
    beat.stamp     = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      beat.op = OP_LOOKUP;
      if (shadow_count != 0 && $urandom_range(0, 2) != 0)
        beat.mac = shadow_mac[$urandom_range(0, shadow_count - 1)];
    end else if (roll < 25 + add_pct) begin
      // fresh MAC and IP: a new host unless the table is full
    end else if (roll < 70 && shadow_count != 0) begin
      // refresh a known host, sometimes with another host's IP
      beat.mac = shadow_mac[$urandom_range(0, shadow_count - 1)];
      if ($urandom_range(0, 2) == 0)
        beat.ip = shadow_ip[$urandom_range(0, shadow_count - 1)];
    end else if (shadow_count != 0) begin
      // unknown MAC claiming a held IP, half the time our own MAC
      if ($urandom_range(0, 1) == 1) beat.mac = shadow_own_mac;
      beat.ip = shadow_ip[$urandom_range(0, shadow_count - 1)];
    end
    return beat;
  endfunction

  task automatic test_learn_new_hosts();
    set_own_mac('0);
    look_up('0);                          // empty table
    announce(HOST_A, '0, '0, '0, '0);     // first host, all-zero fields
    announce('0, '0, '0, '0, '0);         // own MAC takes a held IP
    announce(HOST_B, '0, '0, '0, '0);     // plain IP clash
  endtask

  task automatic test_own_ip_conflict();
    set_own_mac('1);
    announce('1, '0, 64'h1, 16'h1, 32'h1);
    announce('1, '1, '1, '1, '1);         // all-ones host gets added
    announce('0, LAN_IP, '0, '0, '0);
  endtask

  task automatic test_refresh_known_host();
    announce('0, '1, 64'h6C6F_6361_6C68_6F73, 16'h7431, 32'd1000);  // IP already held
    announce(HOST_A, LAN_IP, '1, '0, 32'd2000);
    announce(HOST_A, LAN_IP, '0, '1, '1);
  endtask

  task automatic test_lookup_by_mac();
    look_up('1);
    look_up('0);
    look_up(HOST_A);
    look_up(HOST_B);
    announce(HOST_B, '1, '0, '0, '0);     // IP held by two entries
  endtask

  task automatic test_random_traffic(int src_pct, int sink_pct, int n_items, int add_pct);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    set_own_mac(wide[MAC_W-1:0]);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) settle_table();
      send_beat(make_host_item(add_pct));
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = 1'b0;
    in_ch.mac_address = '0;
    in_ch.ip_address  = '0;
    in_ch.name_low    = '0;
    in_ch.name_high   = '0;
    in_ch.now_seconds = '0;
    out_ch.ready      = 1'b0;
    src_idle_pct      = 25;
    sink_idle_pct     = 74;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_learn_new_hosts();
    test_own_ip_conflict();
    test_refresh_known_host();
    test_lookup_by_mac();
    test_random_traffic(25, 74, 220, 15);
    test_random_traffic(74, 25, 220, 15);
    test_random_traffic(0, 0, 190, 10);
    settle_table();

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
